// ===== design/ippap_pkg.sv =====
// shared types, codes and constants of the ipp request attribute parser
package ippap_pkg;

  localparam int unsigned MAX_REQUEST_BYTES = 32768;
  localparam int unsigned MAX_FORMAT_LENGTH = 128;
  localparam int unsigned FMT_NAME_LEN      = 15;

  localparam logic [7:0] OP_ATTR_TAG = 8'h01;
  localparam logic [7:0] END_TAG     = 8'h03;
  localparam logic [7:0] JOB_TAG     = 8'h04;

  localparam logic [15:0] VERSION_CLAMP = 16'h0200;

  localparam logic [1:0] KIND_FMT_BEGIN = 2'd0;
  localparam logic [1:0] KIND_FMT_BYTE  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY   = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TOO_SHORT = 3'd1;
  localparam logic [2:0] ERR_NO_OP_TAG = 3'd2;
  localparam logic [2:0] ERR_NLEN_CUT  = 3'd3;
  localparam logic [2:0] ERR_NAME_CUT  = 3'd4;
  localparam logic [2:0] ERR_VALUE_CUT = 3'd5;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] total_length;
    logic        end_of_request;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  format_byte;
    logic [6:0]  format_length;
    logic        parse_ok;
    logic [2:0]  error_code;
    logic [15:0] ipp_version;
    logic [15:0] operation_id;
    logic [31:0] request_number;
    logic [15:0] document_offset;
    logic        format_given;
    logic        last_result;
  } out_res_t;

  // results caused by one request byte, first one in res0
  typedef struct packed {
    logic [1:0] count;
    out_res_t   res0;
    out_res_t   res1;
  } step_res_t;

  // characters of the attribute name "document-format"
  function automatic logic [7:0] fmt_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "d";
      4'd1:    c = "o";
      4'd2:    c = "c";
      4'd3:    c = "u";
      4'd4:    c = "m";
      4'd5:    c = "e";
      4'd6:    c = "n";
      4'd7:    c = "t";
      4'd8:    c = "-";
      4'd9:    c = "f";
      4'd10:   c = "o";
      4'd11:   c = "r";
      4'd12:   c = "m";
      4'd13:   c = "a";
      4'd14:   c = "t";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/ippap_parser.sv =====
// parse state of the attribute walk and the results each request byte causes
module ippap_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  ippap_pkg::in_req_t req_i,
  output ippap_pkg::step_res_t step_o
);
  import ippap_pkg::*;

  typedef enum logic [3:0] {
    PH_HDR, PH_OPTAG, PH_TAG, PH_NLEN_HI, PH_NLEN_LO,
    PH_NAME, PH_VLEN_HI, PH_VLEN_LO, PH_VALUE, PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] rem_q, rem_d;
  logic        nm_q, nm_d;
  logic [3:0]  idx_q, idx_d;
  logic [15:0] ver_q, ver_d;
  logic [15:0] op_q, op_d;
  logic [31:0] rid_q, rid_d;
  logic        fs_q, fs_d;
  logic        cap_q, cap_d;

  always_comb begin
    logic [16:0] pos;
    logic [17:0] len;
    logic [15:0] rem;
    logic [15:0] ver;
    logic [7:0]  b;
    logic        len_bad;
    logic        want_tag;
    logic        fin;
    logic [2:0]  fin_err;
    logic [15:0] fin_off;
    logic        emit;
    logic [1:0]  emit_kind;
    logic [7:0]  emit_byte;
    logic [6:0]  emit_len;
    out_res_t    fin_res;
    out_res_t    emit_res;

    b   = req_i.data_byte;
    len = {2'b00, req_i.total_length};
    pos = {1'b0, pos_q} + 17'd1;
    len_bad = (req_i.total_length < 16'd9) ||
              ({1'b0, req_i.total_length} > 17'(MAX_REQUEST_BYTES));
    rem = 16'h0000;
    ver = 16'h0000;

    phase_d = phase_q;
    rem_d   = rem_q;
    nm_d    = nm_q;
    idx_d   = idx_q;
    ver_d   = ver_q;
    op_d    = op_q;
    rid_d   = rid_q;
    fs_d    = fs_q;
    cap_d   = cap_q;

    want_tag  = 1'b0;
    fin       = 1'b0;
    fin_err   = ERR_NONE;
    fin_off   = 16'h0000;
    emit      = 1'b0;
    emit_kind = KIND_FMT_BEGIN;
    emit_byte = 8'h00;
    emit_len  = 7'h00;

    case (phase_q)
      PH_HDR, PH_OPTAG: begin
        if (len_bad) begin
          fin     = 1'b1;
          fin_err = ERR_TOO_SHORT;
        end else if (phase_q == PH_HDR) begin
          if (pos_q == 16'd0) begin
            ver_d = {b, 8'h00};
          end else if (pos_q == 16'd1) begin
            ver = {ver_q[15:8], b};
            if (ver == 16'h0000 || ver > VERSION_CLAMP) begin
              ver_d = VERSION_CLAMP;
            end else begin
              ver_d = ver;
            end
          end else if (pos_q == 16'd2) begin
            op_d = {b, 8'h00};
          end else if (pos_q == 16'd3) begin
            op_d = {op_q[15:8], b};
          end else begin
            rid_d = {rid_q[23:0], b};
          end
          if (pos_q >= 16'd7) begin
            phase_d = PH_OPTAG;
          end
        end else begin
          if (b != OP_ATTR_TAG) begin
            fin     = 1'b1;
            fin_err = ERR_NO_OP_TAG;
          end else begin
            want_tag = 1'b1;
          end
        end
      end
      PH_TAG: begin
        if (b == END_TAG || b == JOB_TAG) begin
          fin     = 1'b1;
          fin_err = ERR_NONE;
          fin_off = pos[15:0];
        end else if (({1'b0, pos} + 18'd2) > len) begin
          fin     = 1'b1;
          fin_err = ERR_NLEN_CUT;
        end else begin
          phase_d = PH_NLEN_HI;
        end
      end
      PH_NLEN_HI: begin
        rem_d   = {b, 8'h00};
        phase_d = PH_NLEN_LO;
      end
      PH_NLEN_LO: begin
        rem   = {rem_q[15:8], b};
        rem_d = rem;
        if (({1'b0, pos} + {2'b00, rem} + 18'd2) > len) begin
          fin     = 1'b1;
          fin_err = ERR_NAME_CUT;
        end else begin
          nm_d    = (rem == 16'(FMT_NAME_LEN));
          idx_d   = 4'd0;
          phase_d = (rem == 16'h0000) ? PH_VLEN_HI : PH_NAME;
        end
      end
      PH_NAME: begin
        if (nm_q && ({1'b0, idx_q} < 5'(FMT_NAME_LEN))) begin
          if (b != fmt_char(idx_q)) begin
            nm_d = 1'b0;
          end
          idx_d = idx_q + 4'd1;
        end
        rem_d = rem_q - 16'd1;
        if (rem_d == 16'h0000) begin
          phase_d = PH_VLEN_HI;
        end
      end
      PH_VLEN_HI: begin
        rem_d   = {b, 8'h00};
        phase_d = PH_VLEN_LO;
      end
      PH_VLEN_LO: begin
        rem   = {rem_q[15:8], b};
        rem_d = rem;
        if (({1'b0, pos} + {2'b00, rem}) > len) begin
          fin     = 1'b1;
          fin_err = ERR_VALUE_CUT;
        end else begin
          cap_d = 1'b0;
          if (nm_q && ({1'b0, rem} < 17'(MAX_FORMAT_LENGTH))) begin
            emit      = 1'b1;
            emit_kind = KIND_FMT_BEGIN;
            emit_len  = rem[6:0];
            fs_d      = 1'b1;
            cap_d     = 1'b1;
          end
          if (rem == 16'h0000) begin
            cap_d    = 1'b0;
            want_tag = 1'b1;
          end else begin
            phase_d = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        if (cap_q) begin
          emit      = 1'b1;
          emit_kind = KIND_FMT_BYTE;
          emit_byte = b;
        end
        rem_d = rem_q - 16'd1;
        if (rem_d == 16'h0000) begin
          cap_d    = 1'b0;
          want_tag = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // next entry needs tag plus a two byte name length at least
    if (want_tag) begin
      if (({1'b0, pos} + 18'd3) > len) begin
        fin     = 1'b1;
        fin_err = ERR_NONE;
        fin_off = pos[15:0];
      end else begin
        phase_d = PH_TAG;
      end
    end

    // early end of request closes an open walk
    if (req_i.end_of_request && !fin && phase_q != PH_DONE) begin
      fin = 1'b1;
      case (phase_d)
        PH_HDR, PH_OPTAG:       fin_err = ERR_TOO_SHORT;
        PH_TAG: begin
          fin_err = ERR_NONE;
          fin_off = pos[15:0];
        end
        PH_NLEN_HI, PH_NLEN_LO: fin_err = ERR_NLEN_CUT;
        PH_VALUE:               fin_err = ERR_VALUE_CUT;
        default:                fin_err = ERR_NAME_CUT;
      endcase
    end

    pos_d = (pos_q == 16'hFFFF) ? pos_q : pos[15:0];

    emit_res               = '0;
    emit_res.kind          = emit_kind;
    emit_res.format_byte   = emit_byte;
    emit_res.format_length = emit_len;
    emit_res.last_result   = !fin;

    fin_res                 = '0;
    fin_res.kind            = KIND_SUMMARY;
    fin_res.parse_ok        = (fin_err == ERR_NONE);
    fin_res.error_code      = fin_err;
    fin_res.ipp_version     = (fin_err != ERR_TOO_SHORT) ? ver_d : 16'h0000;
    fin_res.operation_id    = (fin_err != ERR_TOO_SHORT) ? op_d : 16'h0000;
    fin_res.request_number  = (fin_err != ERR_TOO_SHORT) ? rid_d : 32'h0;
    fin_res.document_offset = (fin_err == ERR_NONE) ? fin_off : 16'h0000;
    fin_res.format_given    = fs_d;
    fin_res.last_result     = 1'b1;

    step_o.count = {1'b0, emit} + {1'b0, fin};
    step_o.res0  = emit ? emit_res : fin_res;
    step_o.res1  = fin_res;

    if (fin) begin
      phase_d = PH_DONE;
      cap_d   = 1'b0;
    end

    if (req_i.end_of_request) begin
      phase_d = PH_HDR;
      pos_d   = 16'h0000;
      rem_d   = 16'h0000;
      nm_d    = 1'b1;
      idx_d   = 4'd0;
      ver_d   = 16'h0000;
      op_d    = 16'h0000;
      rid_d   = 32'h0;
      fs_d    = 1'b0;
      cap_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      pos_q   <= 16'h0000;
      rem_q   <= 16'h0000;
      nm_q    <= 1'b1;
      idx_q   <= 4'd0;
      ver_q   <= 16'h0000;
      op_q    <= 16'h0000;
      rid_q   <= 32'h0;
      fs_q    <= 1'b0;
      cap_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      nm_q    <= nm_d;
      idx_q   <= idx_d;
      ver_q   <= ver_d;
      op_q    <= op_d;
      rid_q   <= rid_d;
      fs_q    <= fs_d;
      cap_q   <= cap_d;
    end
  end

endmodule

// ===== design/ipp_request_attribute_parser_core.sv =====
// top level of the ipp request attribute parser: handshake and result queue
//
// input channel: one request byte per request, with the body's total length
// and an end-of-request flag on the final byte; accepted when in_valid_i is
// high and in_stall_o is low
// output channel: result items (format value begins, format value byte,
// parse summary), taken when out_valid_o is high and out_stall_i is low;
// last_result marks the final result caused by one input byte
// each result enters the queue as its byte is accepted, behind older ones
// throughput: one byte per cycle unless stalled; the walk state is updated
// on acceptance by a single pass of logic, so the next byte follows
// at once; a byte that causes two results (format begin with summary, or
// value byte with summary) takes two output transfers, from a four-entry queue
// in_stall_o rises while more than two results sit in the queue, so a
// stalling receiver holds back request bytes once three or four results wait
// reset clears the walk to the header phase and empties the queue; no
// clearing pass is needed
module ipp_request_attribute_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ippap_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ippap_pkg::out_res_t out_res_o
);
  import ippap_pkg::*;

  // result queue
  out_res_t    queue_q [4];
  logic [1:0]  wr_ptr_q, wr_ptr_d;
  logic [1:0]  rd_ptr_q, rd_ptr_d;
  logic [2:0]  count_q, count_d;

  logic      in_accept;
  logic      out_pop;
  step_res_t step;

  // room for the worst case of two results from the next request
  assign in_stall_o  = (count_q > 3'd2);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != 3'd0);
  assign out_pop     = out_valid_o && !out_stall_i;
  assign out_res_o   = queue_q[rd_ptr_q];

  ippap_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .req_i    (in_req_i),
    .step_o   (step)
  );

  always_comb begin
    logic [1:0] pushed;
    pushed   = in_accept ? step.count : 2'd0;
    wr_ptr_d = wr_ptr_q + pushed;
    rd_ptr_d = out_pop ? (rd_ptr_q + 2'd1) : rd_ptr_q;
    count_d  = count_q + {1'b0, pushed} - {2'b00, out_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue payload, written in order: first result, then the second
  always_ff @(posedge clk_i) begin
    if (in_accept && step.count != 2'd0) begin
      queue_q[wr_ptr_q] <= step.res0;
      if (step.count == 2'd2) begin
        queue_q[wr_ptr_q + 2'd1] <= step.res1;
      end
    end
  end

endmodule

// ===== bench/tb_ipp_request_attribute_parser_core.sv =====
// self-checking bench for the ipp request attribute parser core
module tb_ipp_request_attribute_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ippap_pkg::*;

  // walk phases of the bench's own copy of the parser
  typedef enum logic [3:0] {
    PH_HEADER,
    PH_OP_TAG,
    PH_ENTRY_TAG,
    PH_NAME_LEN_HI,
    PH_NAME_LEN_LO,
    PH_NAME,
    PH_VALUE_LEN_HI,
    PH_VALUE_LEN_LO,
    PH_VALUE,
    PH_FINISHED
  } walk_phase_e;

  // one line of the opening script; a summary is typed in where typed is set
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] len;
    logic        eor;
    logic        typed;
    logic [2:0]  err;
    logic [15:0] ver;
    logic [15:0] op;
    logic [31:0] rid;
    logic [15:0] off;
  } script_row_t;

  localparam int unsigned RANDOM_BYTES    = 1800;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned TAIL_BYTES      = 48;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam longint unsigned TIMEOUT_NS  = 20_000_000;

  localparam logic [119:0] FORMAT_NAME = "document-format";

  // attribute tags used for entries, none of them ends the walk
  localparam logic [7:0] VALUE_TAGS [10] = '{
    8'h02, 8'h05, 8'h21, 8'h23, 8'h41, 8'h42, 8'h44, 8'h45, 8'h47, 8'h49
  };

  // directed opening: length extremes, early end in the header, bytes after
  // the summary, a minimal body that ends at once and a missing op tag
  localparam script_row_t OPENING [25] = '{
    // body too short: summary on the first byte, the rest is ignored
    '{8'hAA, 16'd5,     1'b0, 1'b1, ERR_TOO_SHORT, 16'h0, 16'h0, 32'h0, 16'h0},
    '{8'h55, 16'd5,     1'b1, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    // body too long, one past the limit and the top of the field
    '{8'hFF, 16'd32769, 1'b1, 1'b1, ERR_TOO_SHORT, 16'h0, 16'h0, 32'h0, 16'h0},
    '{8'h00, 16'hFFFF,  1'b1, 1'b1, ERR_TOO_SHORT, 16'h0, 16'h0, 32'h0, 16'h0},
    // zero length, then the closing byte that only clears
    '{8'h00, 16'd0,     1'b0, 1'b1, ERR_TOO_SHORT, 16'h0, 16'h0, 32'h0, 16'h0},
    '{8'h00, 16'd0,     1'b1, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    // largest legal length but the body ends inside the header
    '{8'h01, 16'd32768, 1'b1, 1'b1, ERR_TOO_SHORT, 16'h0, 16'h0, 32'h0, 16'h0},
    // nine bytes, version zero clamps, all-ones ids, walk ends after op tag
    '{8'h00, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'h00, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'hFF, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'hFF, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'hFF, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'hFF, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'hFF, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'hFF, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{OP_ATTR_TAG, 16'd9, 1'b1, 1'b1, ERR_NONE,
      VERSION_CLAMP, 16'hFFFF, 32'hFFFF_FFFF, 16'd9},
    // version just above the clamp, then a wrong op tag
    '{8'h02, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'h01, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'h00, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'h02, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'h00, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'h00, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'h00, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'h00, 16'd9,     1'b0, 1'b0, ERR_NONE,      16'h0, 16'h0, 32'h0, 16'h0},
    '{8'h02, 16'd9,     1'b1, 1'b1, ERR_NO_OP_TAG,
      VERSION_CLAMP, 16'h0002, 32'h0, 16'h0}
  };

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_res_t out_res_o;

  // bench copy of the parser state
  walk_phase_e w_phase;
  logic [15:0] w_position;
  logic [15:0] w_remaining;
  logic        w_name_match;
  logic [3:0]  w_name_idx;
  logic [15:0] w_version;
  logic [15:0] w_operation;
  logic [31:0] w_request_id;
  logic        w_finished;
  logic        w_format_seen;
  logic        w_capture;

  out_res_t    step_out[$];     // results caused by the request just taken
  out_res_t    due_results[$];  // results still owed by the block, oldest first
  logic [7:0]  body[$];         // message body about to be sent
  logic [15:0] body_length;

  int unsigned walked_bytes = 0;
  int unsigned mismatches   = 0;
  bit          no_gaps      = 1'b0;
  bit          hold_off_due = 1'b0;

  ipp_request_attribute_parser_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] name_char(input int unsigned idx);
    return FORMAT_NAME[8 * (FMT_NAME_LEN - 1 - idx) +: 8];
  endfunction

  function automatic out_res_t summary_res(input logic [2:0] err, input logic [15:0] ver,
                                           input logic [15:0] op, input logic [31:0] rid,
                                           input logic [15:0] off, input logic given);
    out_res_t res;
    res                 = '0;
    res.kind            = KIND_SUMMARY;
    res.parse_ok        = (err == ERR_NONE);
    res.error_code      = err;
    res.ipp_version     = ver;
    res.operation_id    = op;
    res.request_number  = rid;
    res.document_offset = off;
    res.format_given    = given;
    return res;
  endfunction

  function automatic out_res_t format_res(input logic [1:0] kind, input logic [7:0] fbyte,
                                          input logic [6:0] flen);
    out_res_t res;
    res               = '0;
    res.kind          = kind;
    res.format_byte   = fbyte;
    res.format_length = flen;
    return res;
  endfunction

  function automatic void clear_walk();
    w_phase       = PH_HEADER;
    w_position    = '0;
    w_remaining   = '0;
    w_name_match  = 1'b1;
    w_name_idx    = '0;
    w_version     = '0;
    w_operation   = '0;
    w_request_id  = '0;
    w_finished    = 1'b0;
    w_format_seen = 1'b0;
    w_capture     = 1'b0;
  endfunction

  // summary ends the walk; header fields are blanked when the body was too short
  function automatic void close_walk(input logic [2:0] err, input int unsigned off);
    logic keep_hdr;
    keep_hdr = (err != ERR_TOO_SHORT);
    step_out.push_back(summary_res(err,
                                   keep_hdr ? w_version : 16'h0000,
                                   keep_hdr ? w_operation : 16'h0000,
                                   keep_hdr ? w_request_id : 32'h0,
                                   (err == ERR_NONE) ? off[15:0] : 16'h0000,
                                   w_format_seen));
    w_phase    = PH_FINISHED;
    w_finished = 1'b1;
    w_capture  = 1'b0;
  endfunction

  // a new entry needs at least three bytes left, else the walk ends cleanly
  function automatic void open_entry(input int unsigned next, input int unsigned len);
    if (next + 3 > len) close_walk(ERR_NONE, next);
    else w_phase = PH_ENTRY_TAG;
  endfunction

  // works out the results that one accepted body byte causes
  function automatic void parse_byte(input in_req_t r);
    int unsigned len, p, pos;
    logic [7:0]  b;
    out_res_t    tail;
    b   = r.data_byte;
    len = r.total_length;
    p   = w_position;
    pos = p + 1;
    step_out.delete();
    case (w_phase)
      PH_HEADER, PH_OP_TAG: begin
        if (len < 9 || len > MAX_REQUEST_BYTES) begin
          close_walk(ERR_TOO_SHORT, 0);
        end else if (w_phase == PH_HEADER) begin
          case (p)
            0: w_version = {b, 8'h00};
            1: begin
              w_version = {w_version[15:8], b};
              if (w_version == 16'h0000 || w_version > VERSION_CLAMP) w_version = VERSION_CLAMP;
            end
            2: w_operation = {b, 8'h00};
            3: w_operation = {w_operation[15:8], b};
            default: w_request_id = {w_request_id[23:0], b};
          endcase
          if (p >= 7) w_phase = PH_OP_TAG;
        end else if (b != OP_ATTR_TAG) begin
          close_walk(ERR_NO_OP_TAG, 0);
        end else begin
          open_entry(pos, len);
        end
      end
      PH_ENTRY_TAG: begin
        if (b == END_TAG || b == JOB_TAG) close_walk(ERR_NONE, pos);
        else if (pos + 2 > len) close_walk(ERR_NLEN_CUT, 0);
        else w_phase = PH_NAME_LEN_HI;
      end
      PH_NAME_LEN_HI: begin
        w_remaining = {b, 8'h00};
        w_phase     = PH_NAME_LEN_LO;
      end
      PH_NAME_LEN_LO: begin
        w_remaining = {w_remaining[15:8], b};
        if (pos + w_remaining + 2 > len) begin
          close_walk(ERR_NAME_CUT, 0);
        end else begin
          w_name_match = (w_remaining == FMT_NAME_LEN);
          w_name_idx   = '0;
          w_phase      = (w_remaining == 16'h0000) ? PH_VALUE_LEN_HI : PH_NAME;
        end
      end
      PH_NAME: begin
        if (w_name_match && w_name_idx < FMT_NAME_LEN) begin
          if (b != name_char(w_name_idx)) w_name_match = 1'b0;
          w_name_idx = w_name_idx + 4'd1;
        end
        w_remaining = w_remaining - 16'd1;
        if (w_remaining == 16'h0000) w_phase = PH_VALUE_LEN_HI;
      end
      PH_VALUE_LEN_HI: begin
        w_remaining = {b, 8'h00};
        w_phase     = PH_VALUE_LEN_LO;
      end
      PH_VALUE_LEN_LO: begin
        w_remaining = {w_remaining[15:8], b};
        if (pos + w_remaining > len) begin
          close_walk(ERR_VALUE_CUT, 0);
        end else begin
          w_capture = 1'b0;
          if (w_name_match && w_remaining < MAX_FORMAT_LENGTH) begin
            step_out.push_back(format_res(KIND_FMT_BEGIN, 8'h00, w_remaining[6:0]));
            w_format_seen = 1'b1;
            w_capture     = 1'b1;
          end
          if (w_remaining == 16'h0000) begin
            w_capture = 1'b0;
            open_entry(pos, len);
          end else begin
            w_phase = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        if (w_capture) step_out.push_back(format_res(KIND_FMT_BYTE, b, 7'd0));
        w_remaining = w_remaining - 16'd1;
        if (w_remaining == 16'h0000) begin
          w_capture = 1'b0;
          open_entry(pos, len);
        end
      end
      default: ;
    endcase

    if (w_position != 16'hFFFF) w_position = w_position + 16'd1;

    // early end: the error depends on where the walk was cut off
    if (r.end_of_request) begin
      if (!w_finished) begin
        case (w_phase)
          PH_HEADER, PH_OP_TAG:           close_walk(ERR_TOO_SHORT, 0);
          PH_ENTRY_TAG:                   close_walk(ERR_NONE, pos);
          PH_NAME_LEN_HI, PH_NAME_LEN_LO: close_walk(ERR_NLEN_CUT, 0);
          PH_VALUE:                       close_walk(ERR_VALUE_CUT, 0);
          default:                        close_walk(ERR_NAME_CUT, 0);
        endcase
      end
      clear_walk();
    end

    if (step_out.size() != 0) begin
      tail             = step_out.pop_back();
      tail.last_result = 1'b1;
      step_out.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // mostly back to back, now and then a long pause
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 2);
    if (roll < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // body with random content, rarely a wrong op tag, then maybe a shorter or longer length field or an early cut
  function automatic void build_request(input bit with_format);
    int unsigned entries, e, style, nlen, vlen, sz, k, roll;
    logic [15:0] word16;
    logic [31:0] word32;
    logic [7:0]  name_buf[$];
    body.delete();
    case ($urandom_range(0, 5))
      0:       word16 = 16'h0000;
      1:       word16 = 16'h0100;
      2:       word16 = VERSION_CLAMP;
      3:       word16 = 16'h0201;
      default: word16 = 16'($urandom);
    endcase
    body.push_back(word16[15:8]);
    body.push_back(word16[7:0]);
    word16 = 16'($urandom);
    body.push_back(word16[15:8]);
    body.push_back(word16[7:0]);
    word32 = $urandom;
    for (k = 0; k < 4; k++) body.push_back(word32[8 * (3 - k) +: 8]);
    if (!with_format && $urandom_range(0, 11) == 0) body.push_back(8'($urandom));
    else body.push_back(OP_ATTR_TAG);

    entries = with_format ? $urandom_range(1, 3) : $urandom_range(0, 3);
    for (e = 0; e < entries; e++) begin
      body.push_back(VALUE_TAGS[$urandom_range(0, 9)]);
      style = (with_format && e == 0) ? 0 : $urandom_range(0, 9);
      name_buf.delete();
      case (style)
        0, 1, 2, 3, 4: begin
          for (k = 0; k < FMT_NAME_LEN; k++) name_buf.push_back(name_char(k));
        end
        5: begin
          // one character off
          for (k = 0; k < FMT_NAME_LEN; k++) name_buf.push_back(name_char(k));
          k = $urandom_range(0, FMT_NAME_LEN - 1);
          name_buf[k] = name_buf[k] ^ 8'h20;
        end
        6: ;
        7: begin
          repeat ($urandom_range(1, 20)) name_buf.push_back(8'($urandom));
        end
        8: begin
          for (k = 0; k < FMT_NAME_LEN - 1; k++) name_buf.push_back(name_char(k));
        end
        default: begin
          for (k = 0; k < FMT_NAME_LEN; k++) name_buf.push_back(name_char(k));
          name_buf.push_back("s");
        end
      endcase
      nlen = name_buf.size();
      body.push_back(nlen[15:8]);
      body.push_back(nlen[7:0]);
      foreach (name_buf[i]) body.push_back(name_buf[i]);

      if (with_format && e == 0) begin
        vlen = 40;
      end else if (style <= 4) begin
        // format values: mostly short, sometimes around the capture limit
        roll = $urandom_range(0, 19);
        if (roll < 14)       vlen = $urandom_range(0, 8);
        else if (roll < 16)  vlen = $urandom_range(9, MAX_FORMAT_LENGTH - 2);
        else if (roll == 16) vlen = MAX_FORMAT_LENGTH - 1;
        else if (roll == 17) vlen = MAX_FORMAT_LENGTH;
        else if (roll == 18) vlen = MAX_FORMAT_LENGTH + 1;
        else                 vlen = 0;
      end else begin
        vlen = $urandom_range(0, 6);
      end
      body.push_back(vlen[15:8]);
      body.push_back(vlen[7:0]);
      repeat (vlen) body.push_back(8'($urandom));
    end

    // no end tag lets the walk run out of bytes instead
    case ($urandom_range(0, 5))
      0:       ;
      1:       body.push_back(JOB_TAG);
      default: body.push_back(END_TAG);
    endcase
    repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));

    sz          = body.size();
    body_length = 16'(sz);
    if (!with_format) begin
      case ($urandom_range(0, 9))
        0, 1:    body_length = 16'(sz - $urandom_range(1, (sz < 24) ? sz : 24));
        2:       body_length = 16'(sz + $urandom_range(1, 8));
        default: ;
      endcase
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, sz);
        while (body.size() > k) void'(body.pop_back());
      end
    end
  endfunction

  function automatic void build_noise();
    body.delete();
    repeat ($urandom_range(1, 12)) body.push_back(8'($urandom));
    body_length = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 16)) : 16'($urandom);
  endfunction

  // offers one request and waits for it to be taken; a typed result replaces
  // the predicted ones, the prediction still moves the walk on
  task automatic offer_byte(input in_req_t r, input bit typed, input out_res_t want);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (w_phase != PH_FINISHED) walked_bytes++;
    parse_byte(r);
    if (typed) due_results.push_back(want);
    else foreach (step_out[i]) due_results.push_back(step_out[i]);
  endtask

  // sends the built body; wobble varies the length field from byte to byte
  task automatic send_body(input bit wobble);
    in_req_t  r;
    out_res_t none;
    none = '0;
    foreach (body[i]) begin
      r.data_byte      = body[i];
      r.total_length   = (wobble && $urandom_range(0, 1) == 1) ? 16'($urandom) : body_length;
      r.end_of_request = (i == body.size() - 1);
      offer_byte(r, 1'b0, none);
    end
  endtask

  initial begin : stimulus
    script_row_t row;
    in_req_t     req;
    out_res_t    want;
    int unsigned k;
    clear_walk();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed opening
    foreach (OPENING[i]) begin
      row                = OPENING[i];
      req.data_byte      = row.data;
      req.total_length   = row.len;
      req.end_of_request = row.eor;
      want               = summary_res(row.err, row.ver, row.op, row.rid, row.off, 1'b0);
      want.last_result   = 1'b1;
      offer_byte(req, row.typed, want);
    end

    // receiver holds off while a long format value streams in, so the
    // result queue fills and the input is stalled
    hold_off_due = 1'b1;
    no_gaps      = 1'b1;
    build_request(1'b1);
    send_body(1'b0);

    // summary on the first byte, then a tail of ignored bytes with random
    // lengths before the closing byte
    want               = '0;
    req.data_byte      = 8'h5A;
    req.total_length   = 16'd3;
    req.end_of_request = 1'b0;
    offer_byte(req, 1'b0, want);
    for (k = 0; k < TAIL_BYTES; k++) begin
      req.data_byte      = 8'($urandom);
      req.total_length   = 16'($urandom);
      req.end_of_request = (k == TAIL_BYTES - 1);
      offer_byte(req, 1'b0, want);
    end

    // random bodies, mostly well formed, some plain noise
    while (walked_bytes < RANDOM_BYTES) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) begin
        build_noise();
        send_body(1'b1);
      end else begin
        build_request(1'b0);
        send_body(1'b0);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver and checking
  // ---------------------------------------------------------------------------

  // stall pattern in segments: short bursts, calm stretches, rare long stalls
  initial begin : result_taker
    int unsigned run;
    int unsigned roll;
    logic        stalling;
    run = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        out_stall_i <= 1'b1;
        run = HOLD_OFF_CYCLES - 1;
      end else if (run != 0) begin
        run--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          stalling = 1'b0;
          run      = $urandom_range(1, 6);
        end else if (roll < 75) begin
          stalling = 1'b1;
          run      = $urandom_range(1, 3);
        end else if (roll < 88) begin
          stalling = 1'b0;
          run      = $urandom_range(20, 80);
        end else if (roll < 97) begin
          stalling = 1'b1;
          run      = $urandom_range(4, 10);
        end else begin
          stalling = 1'b1;
          run      = $urandom_range(20, 40);
        end
        out_stall_i <= stalling;
        run = run - 1;
      end
    end
  end

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    out_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $error("result with nothing due: kind %0d", out_res_o.kind);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("kind",            want.kind,            out_res_o.kind);
        check_field("format_byte",     want.format_byte,     out_res_o.format_byte);
        check_field("format_length",   want.format_length,   out_res_o.format_length);
        check_field("parse_ok",        want.parse_ok,        out_res_o.parse_ok);
        check_field("error_code",      want.error_code,      out_res_o.error_code);
        check_field("ipp_version",     want.ipp_version,     out_res_o.ipp_version);
        check_field("operation_id",    want.operation_id,    out_res_o.operation_id);
        check_field("request_number",  want.request_number,  out_res_o.request_number);
        check_field("document_offset", want.document_offset, out_res_o.document_offset);
        check_field("format_given",    want.format_given,    out_res_o.format_given);
        check_field("last_result",     want.last_result,     out_res_o.last_result);
      end
    end
  end

endmodule
